[rtl/core/multi_touch_pan_tracker_top_assert.svh]
// Assertion macros used by the checker file of the pan tracker.
`ifndef MULTI_TOUCH_PAN_TRACKER_TOP_ASSERT_SVH
`define MULTI_TOUCH_PAN_TRACKER_TOP_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define MTPT_ASSERT_ON(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Concurrent assertion on the usual clk and arst_n of the enclosing scope.
`define MTPT_ASSERT(lbl, prop, msg) \
	`MTPT_ASSERT_ON(lbl, clk, arst_n, prop, msg)

`endif

[rtl/core/mtpt_pkg.sv]
// Package with the shared constants, codes and control structs of the pan tracker.
`timescale 1ns / 1ps
`default_nettype none
package mtpt_pkg;

	localparam int MAX_TOUCHES = 8;
	localparam int SLOT_W      = (MAX_TOUCHES > 1) ? $clog2(MAX_TOUCHES) : 1;
	localparam int CNT_W       = $clog2(MAX_TOUCHES + 1);
	localparam int ID_W        = 8;
	localparam int POS_W       = 16;
	localparam int SHIFT_W     = 17;
	localparam int FC_W        = 4;
	localparam int SUM_W       = POS_W + 1 + SLOT_W;
	localparam int STEP_W      = $clog2(SUM_W + 1);
	localparam int LANES       = 4;

	typedef enum logic [1:0] {
		MODE_BEGIN  = 2'd0,
		MODE_MOVE   = 2'd1,
		MODE_CANCEL = 2'd2,
		MODE_END    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		PH_POSSIBLE   = 3'd0,
		PH_BEGAN      = 3'd1,
		PH_CHANGED    = 3'd2,
		PH_RECOGNIZED = 3'd3,
		PH_FAILED     = 3'd4
	} phase_t;

	typedef struct packed {
		logic hit;
		logic lt_req;
		logic eq_req;
		logic fill_req;
		logic empty_after;
	} dp_status_t;

	typedef struct packed {
		logic              ins;
		logic              upd;
		logic              rem;
		logic              acc_clear;
		logic              acc_step;
		logic [SLOT_W-1:0] idx;
		logic              div_init;
		logic              div_step;
		logic              commit_center;
		logic              commit_shift;
		logic              load_out;
		logic              out_accepted;
		logic              out_notify;
		phase_t            out_phase;
	} dp_cmd_t;

endpackage
`default_nettype wire

[rtl/core/mtpt_if.sv]
// Channel interfaces of the pan tracker: touch events, results and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface mtpt_evt_if;
	import mtpt_pkg::*;

	logic                    valid;
	logic                    ready;
	mode_t                   mode;
	logic [ID_W-1:0]         touch_id;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;

	modport source (output valid, mode, touch_id, pos_x, pos_y, input ready);
	modport sink (input valid, mode, touch_id, pos_x, pos_y, output ready);
endinterface

interface mtpt_res_if;
	import mtpt_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      accepted;
	logic                      notify;
	phase_t                    gesture_state;
	logic signed [POS_W-1:0]   center_x;
	logic signed [POS_W-1:0]   center_y;
	logic signed [SHIFT_W-1:0] shift_x;
	logic signed [SHIFT_W-1:0] shift_y;

	modport source (output valid, accepted, notify, gesture_state, center_x, center_y,
		shift_x, shift_y, input ready);
	modport sink (input valid, accepted, notify, gesture_state, center_x, center_y,
		shift_x, shift_y, output ready);
endinterface

interface mtpt_cfg_if;
	import mtpt_pkg::*;

	logic            valid;
	logic            ready;
	logic [FC_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/core/mtpt_datapath.sv]
// Datapath of the pan tracker: touch table, slot sweep, serial mean divider and result register.
`timescale 1ns / 1ps
`default_nettype none
module mtpt_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mtpt_pkg::dp_cmd_t                cmd,
	output mtpt_pkg::dp_status_t             status,
	input  logic [mtpt_pkg::ID_W-1:0]        touch_id,
	input  logic signed [mtpt_pkg::POS_W-1:0] pos_x,
	input  logic signed [mtpt_pkg::POS_W-1:0] pos_y,
	input  logic                             cfg_we,
	input  logic [mtpt_pkg::FC_W-1:0]        cfg_data,
	output logic                             res_accepted,
	output logic                             res_notify,
	output mtpt_pkg::phase_t                 res_state,
	output logic signed [mtpt_pkg::POS_W-1:0] res_center_x,
	output logic signed [mtpt_pkg::POS_W-1:0] res_center_y,
	output logic signed [mtpt_pkg::SHIFT_W-1:0] res_shift_x,
	output logic signed [mtpt_pkg::SHIFT_W-1:0] res_shift_y
);
	import mtpt_pkg::*;

	logic [MAX_TOUCHES-1:0]  slot_valid_q;
	logic [ID_W-1:0]         slot_id_q [MAX_TOUCHES];
	logic signed [POS_W-1:0] slot_x_q [MAX_TOUCHES];
	logic signed [POS_W-1:0] slot_y_q [MAX_TOUCHES];
	logic [FC_W-1:0]         finger_count_q;

	logic                    hit;
	logic [SLOT_W-1:0]       hit_idx;
	logic [SLOT_W-1:0]       free_idx;
	logic [CNT_W-1:0]        cnt;
	logic [CNT_W-1:0]        req;

	logic signed [SHIFT_W-1:0] dx_q;
	logic signed [SHIFT_W-1:0] dy_q;
	logic signed [SUM_W-1:0]   acc_x_q;
	logic signed [SUM_W-1:0]   acc_y_q;

	logic [SUM_W-1:0]          quo_q [LANES];
	logic [CNT_W-1:0]          rem_q [LANES];
	logic [LANES-1:0]          neg_q;
	logic signed [SUM_W-1:0]   lane_src [LANES];
	logic [SUM_W-1:0]          quo_nxt [LANES];
	logic [CNT_W-1:0]          rem_nxt [LANES];
	logic signed [SUM_W-1:0]   mean [LANES];

	logic signed [POS_W-1:0]   last_cx_q;
	logic signed [POS_W-1:0]   last_cy_q;
	logic signed [SHIFT_W-1:0] last_sx_q;
	logic signed [SHIFT_W-1:0] last_sy_q;

	// Lookup over the table: the lowest matching slot, the lowest free slot and the fill count.
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		cnt      = '0;
		for (int i = MAX_TOUCHES - 1; i >= 0; i--) begin
			if (slot_valid_q[i] && (slot_id_q[i] == touch_id)) begin
				hit     = 1'b1;
				hit_idx = SLOT_W'(i);
			end
			if (!slot_valid_q[i]) begin
				free_idx = SLOT_W'(i);
			end
			cnt = cnt + CNT_W'(slot_valid_q[i]);
		end
	end

	assign req = (int'(finger_count_q) < MAX_TOUCHES) ? CNT_W'(finger_count_q)
		: CNT_W'(MAX_TOUCHES);

	assign status.hit         = hit;
	assign status.lt_req      = (cnt < req);
	assign status.eq_req      = (cnt == req);
	assign status.fill_req    = (({1'b0, cnt} + (CNT_W + 1)'(!hit)) == {1'b0, req});
	assign status.empty_after = (cnt == CNT_W'(hit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q   <= '0;
			finger_count_q <= FC_W'(1);
		end else begin
			if (cfg_we) begin
				finger_count_q <= cfg_data;
			end
			if (cmd.ins && !hit) begin
				slot_valid_q[free_idx] <= 1'b1;
			end
			if (cmd.rem && hit) begin
				slot_valid_q[hit_idx] <= 1'b0;
			end
		end
	end

	// Slot contents; read only where the valid bit is set.
	always_ff @(posedge clk) begin
		if (cmd.ins && !hit) begin
			slot_id_q[free_idx] <= touch_id;
			slot_x_q[free_idx]  <= pos_x;
			slot_y_q[free_idx]  <= pos_y;
		end
		if (cmd.upd) begin
			slot_x_q[hit_idx] <= pos_x;
			slot_y_q[hit_idx] <= pos_y;
			dx_q <= SHIFT_W'(pos_x) - SHIFT_W'(slot_x_q[hit_idx]);
			dy_q <= SHIFT_W'(pos_y) - SHIFT_W'(slot_y_q[hit_idx]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clear) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (cmd.acc_step && slot_valid_q[cmd.idx]) begin
			acc_x_q <= acc_x_q + SUM_W'(slot_x_q[cmd.idx]);
			acc_y_q <= acc_y_q + SUM_W'(slot_y_q[cmd.idx]);
		end
	end

	// Lanes: new mean x and y, and the mean before the move, recovered from the new sum.
	assign lane_src[0] = acc_x_q;
	assign lane_src[1] = acc_y_q;
	assign lane_src[2] = acc_x_q - SUM_W'(dx_q);
	assign lane_src[3] = acc_y_q - SUM_W'(dy_q);

	// One restoring division step per lane, dividing the magnitude by the fill count.
	always_comb begin
		logic [CNT_W:0] sh;
		for (int l = 0; l < LANES; l++) begin
			sh = {rem_q[l], quo_q[l][SUM_W-1]};
			if (sh >= {1'b0, cnt}) begin
				rem_nxt[l] = CNT_W'(sh - {1'b0, cnt});
				quo_nxt[l] = {quo_q[l][SUM_W-2:0], 1'b1};
			end else begin
				rem_nxt[l] = sh[CNT_W-1:0];
				quo_nxt[l] = {quo_q[l][SUM_W-2:0], 1'b0};
			end
			mean[l] = neg_q[l] ? -$signed(quo_q[l]) : $signed(quo_q[l]);
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (cmd.div_init) begin
				neg_q[l] <= lane_src[l][SUM_W-1];
				quo_q[l] <= lane_src[l][SUM_W-1] ? SUM_W'(-lane_src[l]) : SUM_W'(lane_src[l]);
				rem_q[l] <= '0;
			end else if (cmd.div_step) begin
				quo_q[l] <= quo_nxt[l];
				rem_q[l] <= rem_nxt[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cx_q <= '0;
			last_cy_q <= '0;
			last_sx_q <= '0;
			last_sy_q <= '0;
		end else begin
			if (cmd.commit_center) begin
				last_cx_q <= mean[0][POS_W-1:0];
				last_cy_q <= mean[1][POS_W-1:0];
			end
			// The low bits of the wide means already carry the sign into the shift width.
			if (cmd.commit_shift) begin
				last_sx_q <= mean[0][SHIFT_W-1:0] - mean[2][SHIFT_W-1:0];
				last_sy_q <= mean[1][SHIFT_W-1:0] - mean[3][SHIFT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_accepted <= cmd.out_accepted;
			res_notify   <= cmd.out_notify;
			res_state    <= cmd.out_phase;
			res_center_x <= last_cx_q;
			res_center_y <= last_cy_q;
			res_shift_x  <= last_sx_q;
			res_shift_y  <= last_sy_q;
		end
	end

endmodule
`default_nettype wire

[rtl/core/mtpt_ctrl.sv]
// Controller of the pan tracker: event decode, gesture phase and the sequencing of sweep and divider.
`timescale 1ns / 1ps
`default_nettype none
module mtpt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 evt_valid,
	output logic                 evt_ready,
	input  mtpt_pkg::mode_t      evt_mode,
	output logic                 res_valid,
	input  logic                 res_ready,
	input  mtpt_pkg::dp_status_t status,
	output mtpt_pkg::dp_cmd_t    cmd
);
	import mtpt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_DINIT,
		S_DIV,
		S_FIN,
		S_OUT
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	phase_t            phase_q;
	logic              accepted_q;
	logic              notify_q;
	logic              move_q;

	logic   take;
	logic   d_accepted;
	logic   d_notify;
	logic   d_mean;
	logic   d_move;
	logic   d_ins;
	logic   d_upd;
	logic   d_rem;
	phase_t d_phase;

	assign evt_ready = (state_q == S_IDLE);
	assign take      = evt_valid && evt_ready;

	always_comb begin
		d_accepted = 1'b0;
		d_notify   = 1'b0;
		d_mean     = 1'b0;
		d_move     = 1'b0;
		d_ins      = 1'b0;
		d_upd      = 1'b0;
		d_rem      = 1'b0;
		d_phase    = phase_q;
		case (evt_mode)
			MODE_BEGIN: begin
				if (status.lt_req) begin
					d_accepted = 1'b1;
					d_ins      = 1'b1;
					d_phase    = PH_POSSIBLE;
					if (status.fill_req) begin
						d_phase  = PH_BEGAN;
						d_notify = 1'b1;
						d_mean   = 1'b1;
					end
				end
			end
			MODE_MOVE: begin
				if (status.hit && status.eq_req) begin
					d_upd    = 1'b1;
					d_phase  = PH_CHANGED;
					d_notify = 1'b1;
					d_mean   = 1'b1;
					d_move   = 1'b1;
				end
			end
			MODE_CANCEL: begin
				// The phase becomes failed before the lift, so no recognition can follow.
				d_rem    = 1'b1;
				d_phase  = PH_FAILED;
				d_notify = 1'b1;
			end
			MODE_END: begin
				d_rem = 1'b1;
				if ((phase_q == PH_CHANGED) && status.empty_after) begin
					d_phase  = PH_RECOGNIZED;
					d_notify = 1'b1;
				end
			end
			default: begin
				d_phase = phase_q;
			end
		endcase
	end

	always_comb begin
		cmd               = '0;
		cmd.ins           = take && d_ins;
		cmd.upd           = take && d_upd;
		cmd.rem           = take && d_rem;
		cmd.acc_clear     = take;
		cmd.acc_step      = (state_q == S_SUM);
		cmd.idx           = step_q[SLOT_W-1:0];
		cmd.div_init      = (state_q == S_DINIT);
		cmd.div_step      = (state_q == S_DIV);
		cmd.commit_center = (state_q == S_FIN);
		cmd.commit_shift  = (state_q == S_FIN) && move_q;
		cmd.load_out      = (state_q == S_OUT) && (!res_valid || res_ready);
		cmd.out_accepted  = accepted_q;
		cmd.out_notify    = notify_q;
		cmd.out_phase     = phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= '0;
			phase_q    <= PH_POSSIBLE;
			accepted_q <= 1'b0;
			notify_q   <= 1'b0;
			move_q     <= 1'b0;
			res_valid  <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						phase_q    <= d_phase;
						accepted_q <= d_accepted;
						notify_q   <= d_notify;
						move_q     <= d_move;
						step_q     <= '0;
						state_q    <= d_mean ? S_SUM : S_OUT;
					end
				end
				S_SUM: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(MAX_TOUCHES - 1)) begin
						state_q <= S_DINIT;
					end
				end
				S_DINIT: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (cmd.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/multi_touch_pan_tracker_top.sv]
// Top level of the multi-touch pan tracker: joins the controller, the datapath and the channels.
// A begin that fills the table and a move of a tracked touch pass from acceptance through the
// slot sweep, one step per table entry, and then through the lane-parallel restoring divider,
// one bit a cycle, before a valid result is registered. Every other event skips both.
// One event is in work at a time; the next is taken once the result has been registered.
// Reset (arst_n low) empties the table, sets the phase to possible, clears the last centre and
// shift and sets finger_count to one.
`timescale 1ns / 1ps
`default_nettype none
module multi_touch_pan_tracker_top (
	input  logic       clk,
	input  logic       arst_n,
	mtpt_evt_if.sink   evt,
	mtpt_res_if.source res,
	mtpt_cfg_if.sink   cfg
);
	import mtpt_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg.ready = 1'b1;

	mtpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.evt_mode  (evt.mode),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.status    (status),
		.cmd       (cmd)
	);

	mtpt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.touch_id     (evt.touch_id),
		.pos_x        (evt.pos_x),
		.pos_y        (evt.pos_y),
		.cfg_we       (cfg.valid),
		.cfg_data     (cfg.data),
		.res_accepted (res.accepted),
		.res_notify   (res.notify),
		.res_state    (res.gesture_state),
		.res_center_x (res.center_x),
		.res_center_y (res.center_y),
		.res_shift_x  (res.shift_x),
		.res_shift_y  (res.shift_y)
	);

endmodule
`default_nettype wire

[rtl/core/mtpt_checker.sv]
// Port-level checker of the pan tracker and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_touch_pan_tracker_top_assert.svh"
module mtpt_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             evt_valid,
	input logic             evt_ready,
	input logic             res_valid,
	input logic             res_ready,
	input logic             res_accepted,
	input logic             res_notify,
	input mtpt_pkg::phase_t res_state
);
	import mtpt_pkg::*;

	// A result waiting for the sink is not withdrawn.
	`MTPT_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result dropped while stalled")

	// The block works on one event at a time, so it is busy right after a transaction.
	`MTPT_ASSERT(a_busy_after_take, evt_valid && evt_ready |=> !evt_ready, "event taken while busy")

	// A claimed touch that does not complete the table leaves the gesture possible.
	`MTPT_ASSERT(a_claim_quiet, res_valid && res_accepted && !res_notify |-> res_state == PH_POSSIBLE, "claim without notification not possible")

	// A claimed touch that notifies has completed the table.
	`MTPT_ASSERT(a_claim_fill, res_valid && res_accepted && res_notify |-> res_state == PH_BEGAN, "claim with notification not began")

endmodule

bind multi_touch_pan_tracker_top mtpt_checker u_mtpt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.evt_valid    (evt.valid),
	.evt_ready    (evt.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_accepted (res.accepted),
	.res_notify   (res.notify),
	.res_state    (res.gesture_state)
);
`default_nettype wire
